/* hdl/sbbr_pkg.sv */
// Shared types, constants and float helpers for the splat bounds to bucket range block.
// No dependencies; used by the top level and the testbench.
`timescale 1ns / 1ps

package sbbr_pkg;

    localparam int NUM_LANES  = 6;
    localparam int NUM_STAGES = 9;

    localparam logic [31:0] INT_MIN_BITS    = 32'h8000_0000;
    localparam logic [31:0] INDEX_FLOOR_MIN = 32'h8000_0001;
    localparam logic [31:0] FLOAT_QNAN      = 32'h7FC0_0000;
    localparam logic [7:0]  EXP_MAX         = 8'hFF;

    localparam logic [31:0] INV_SPACING_RESET    = 32'h3F80_0000;
    localparam logic [31:0] DIV_MULTIPLIER_RESET = 32'h0000_0001;
    localparam logic [5:0]  DIV_SHIFT_RESET      = 6'd0;
    localparam logic [31:0] NEG_THRESHOLD_RESET  = 32'h8000_0000;
    localparam logic [31:0] POS_THRESHOLD_RESET  = 32'h7FFF_FFFF;

    typedef enum logic [2:0] {
        REG_INV_SPACING    = 3'd0,
        REG_DIV_MULTIPLIER = 3'd1,
        REG_DIV_SHIFT      = 3'd2,
        REG_NEG_THRESHOLD  = 3'd3,
        REG_POS_THRESHOLD  = 3'd4
    } cfg_reg_t;

    // Aligned add: larger operand's sign and exponent, raw sum with GRS bits
    typedef struct packed {
        logic        special;
        logic        sign;
        logic [7:0]  exp;
        logic [27:0] sum;
    } add_align_t;

    // Product before / after normalization
    typedef struct packed {
        logic               special;
        logic               zero;
        logic               sign;
        logic signed [10:0] exp;
        logic [47:0]        prod;
    } mul_t;

    // Swap, align and add/subtract the significands
    function automatic add_align_t fadd_align(input logic [31:0] a, input logic [31:0] b,
                                              input logic sub);
        logic [31:0] x;
        logic [31:0] y;
        logic        bsign;
        logic [7:0]  ex;
        logic [7:0]  ey;
        logic [7:0]  d;
        logic [23:0] mx;
        logic [23:0] my;
        logic [53:0] t;
        logic [26:0] al;
        logic [27:0] big;
        logic        effsub;
        add_align_t  r;
        bsign = b[31] ^ sub;
        if (a[30:0] >= b[30:0])
        begin
            x = a;
            y = {bsign, b[30:0]};
        end
        else
        begin
            x = {bsign, b[30:0]};
            y = a;
        end
        ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
        ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
        mx = {x[30:23] != 8'd0, x[22:0]};
        my = {y[30:23] != 8'd0, y[22:0]};
        d  = ex - ey;
        t  = {my, 3'b000, 27'd0} >> ((d > 8'd27) ? 8'd27 : d);
        al = t[53:27] | {26'd0, |t[26:0]};
        effsub = x[31] ^ y[31];
        big = {1'b0, mx, 3'b000};
        r.sum = effsub ? (big - {1'b0, al}) : (big + {1'b0, al});
        r.special = (a[30:23] == EXP_MAX) || (b[30:23] == EXP_MAX);
        r.sign = x[31];
        r.exp = ex;
        return r;
    endfunction

    // Normalize and round-to-nearest-even the aligned sum
    function automatic logic [31:0] fadd_round(input add_align_t a);
        logic [8:0]  e;
        logic [26:0] v;
        logic [4:0]  lz;
        logic [4:0]  sh;
        logic        found;
        logic        inc;
        logic [24:0] mr;
        if (a.special)
            return FLOAT_QNAN;
        e = {1'b0, a.exp};
        if (a.sum[27])
        begin
            v = {a.sum[27:2], a.sum[1] | a.sum[0]};
            e = e + 9'd1;
        end
        else
        begin
            lz = 5'd27;
            found = 1'b0;
            for (int i = 26; i >= 0; i--)
            begin
                if (!found && a.sum[i])
                begin
                    lz = 5'(26 - i);
                    found = 1'b1;
                end
            end
            // stop at the subnormal boundary
            sh = ({4'd0, lz} > (e - 9'd1)) ? 5'(e - 9'd1) : lz;
            v = a.sum[26:0] << sh;
            e = e - {4'd0, sh};
        end
        inc = v[2] & (v[1] | v[0] | v[3]);
        mr = {1'b0, v[26:3]} + {24'd0, inc};
        if (mr[24])
        begin
            mr = mr >> 1;
            e = e + 9'd1;
        end
        if (e >= 9'd255)
            return {a.sign, EXP_MAX, 23'd0};
        return {a.sign, mr[23] ? e[7:0] : 8'd0, mr[22:0]};
    endfunction

    // Significand product and exponent sum
    function automatic mul_t fmul_prod(input logic [31:0] a, input logic [31:0] b);
        logic [7:0]  ea;
        logic [7:0]  eb;
        logic [23:0] ma;
        logic [23:0] mb;
        mul_t        r;
        ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        ma = {a[30:23] != 8'd0, a[22:0]};
        mb = {b[30:23] != 8'd0, b[22:0]};
        r.special = (a[30:23] == EXP_MAX) || (b[30:23] == EXP_MAX);
        r.zero = (ma == 24'd0) || (mb == 24'd0);
        r.sign = a[31] ^ b[31];
        r.exp = $signed({3'b000, ea}) + $signed({3'b000, eb}) - 11'sd127;
        r.prod = ma * mb;
        return r;
    endfunction

    // Move the leading one of the product to the top bit
    function automatic mul_t fmul_norm(input mul_t m);
        logic [5:0] lz;
        logic       found;
        mul_t       r;
        lz = 6'd48;
        found = 1'b0;
        for (int i = 47; i >= 0; i--)
        begin
            if (!found && m.prod[i])
            begin
                lz = 6'(47 - i);
                found = 1'b1;
            end
        end
        r = m;
        r.prod = m.prod << lz;
        r.exp = m.exp + 11'sd1 - $signed({5'd0, lz});
        return r;
    endfunction

    // Denormalize if needed, round to nearest even, pack
    function automatic logic [31:0] fmul_round(input mul_t m);
        logic signed [10:0] e;
        logic [47:0]        q;
        logic [10:0]        sh;
        logic [5:0]         amt;
        logic [95:0]        t;
        logic [23:0]        m24;
        logic               inc;
        logic [24:0]        mr;
        if (m.special)
            return FLOAT_QNAN;
        if (m.zero)
            return 32'd0;
        e = m.exp;
        q = m.prod;
        if (e < 11'sd1)
        begin
            sh = 11'(11'sd1 - e);
            amt = (sh > 11'd48) ? 6'd48 : sh[5:0];
            t = {q, 48'd0} >> amt;
            q = t[95:48] | {47'd0, |t[47:0]};
            e = 11'sd1;
        end
        m24 = q[47:24];
        inc = q[23] & ((|q[22:0]) | m24[0]);
        mr = {1'b0, m24} + {24'd0, inc};
        if (mr[24])
        begin
            mr = mr >> 1;
            e = e + 11'sd1;
        end
        if (e >= 11'sd255)
            return {m.sign, EXP_MAX, 23'd0};
        return {m.sign, mr[23] ? e[7:0] : 8'd0, mr[22:0]};
    endfunction

    // Floor to int32; NaN, infinity or out of range gives INT_MIN
    function automatic logic [31:0] floor_cell(input logic [31:0] f);
        logic [7:0]  ef;
        logic [23:0] m;
        logic [31:0] ip;
        logic        frac;
        logic [4:0]  rs;
        ef = (f[30:23] == 8'd0) ? 8'd1 : f[30:23];
        m = {f[30:23] != 8'd0, f[22:0]};
        if (f[30:23] == EXP_MAX || ef >= 8'd158)
            return INT_MIN_BITS;
        if (ef < 8'd127)
            return (f[31] && m != 24'd0) ? 32'hFFFF_FFFF : 32'd0;
        if (ef >= 8'd150)
        begin
            ip = {8'd0, m} << (ef - 8'd150);
            frac = 1'b0;
        end
        else
        begin
            rs = 5'(8'd150 - ef);
            ip = {8'd0, m} >> rs;
            frac = |(m & ~(24'hFF_FFFF << rs));
        end
        if (f[31])
            return 32'd0 - (ip + {31'd0, frac});
        return ip;
    endfunction

endpackage

/* hdl/sbbr_splat_if.sv */
// Input channel: one splat item (position and radius, IEEE single bits).
// Standalone; no package dependency.
`timescale 1ns / 1ps

interface sbbr_splat_if;
    logic        valid;
    logic        ready;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] splat_radius;

    modport source (output valid, pos_x, pos_y, pos_z, splat_radius, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, splat_radius, output ready);
endinterface

/* hdl/sbbr_bucket_if.sv */
// Output channel: one bucket range item per splat.
// Standalone; no package dependency.
`timescale 1ns / 1ps

interface sbbr_bucket_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] lower_x;
    logic signed [63:0] lower_y;
    logic signed [63:0] lower_z;
    logic signed [63:0] upper_x;
    logic signed [63:0] upper_y;
    logic signed [63:0] upper_z;
    logic               range_error;

    modport source (output valid, lower_x, lower_y, lower_z, upper_x, upper_y, upper_z,
                    range_error, input ready);
    modport sink   (input valid, lower_x, lower_y, lower_z, upper_x, upper_y, upper_z,
                    range_error, output ready);
endinterface

/* hdl/splat_bounds_to_bucket_range_top.sv */
// Throughput: one item per cycle unless bucket_out stalls;
// nine pipeline stages (float add align/round, multiply, normalize, round, floor,
// threshold adjust, bucket multiply, shift).
// Each stage holds on its own, so empty stages keep filling while the output stalls.
// Reset (rst_n low, async) empties the pipeline and loads register reset values.
// Depends on sbbr_pkg, sbbr_splat_if and sbbr_bucket_if.
`timescale 1ns / 1ps

module splat_bounds_to_bucket_range_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    sbbr_splat_if.sink         splat_in,
    sbbr_bucket_if.source      bucket_out
);

    localparam int NL = sbbr_pkg::NUM_LANES;
    localparam int NS = sbbr_pkg::NUM_STAGES;

    // configuration registers
    logic [31:0] inv_spacing_reg;
    logic [31:0] div_multiplier_reg;
    logic [5:0]  div_shift_reg;
    logic [31:0] neg_threshold_reg;
    logic [31:0] pos_threshold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_spacing_reg    <= sbbr_pkg::INV_SPACING_RESET;
            div_multiplier_reg <= sbbr_pkg::DIV_MULTIPLIER_RESET;
            div_shift_reg      <= sbbr_pkg::DIV_SHIFT_RESET;
            neg_threshold_reg  <= sbbr_pkg::NEG_THRESHOLD_RESET;
            pos_threshold_reg  <= sbbr_pkg::POS_THRESHOLD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sbbr_pkg::REG_INV_SPACING:    inv_spacing_reg    <= cfg_data;
                sbbr_pkg::REG_DIV_MULTIPLIER: div_multiplier_reg <= cfg_data;
                sbbr_pkg::REG_DIV_SHIFT:      div_shift_reg      <= cfg_data[5:0];
                sbbr_pkg::REG_NEG_THRESHOLD:  neg_threshold_reg  <= cfg_data;
                sbbr_pkg::REG_POS_THRESHOLD:  pos_threshold_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage valids and per-stage advance (stage empty or next one moves)
    logic [NS-1:0] v_reg;
    logic [NS-1:0] adv;
    logic [NS-1:0] vin;

    always_comb
    begin
        adv[NS-1] = !v_reg[NS-1] || bucket_out.ready;
        for (int k = NS - 2; k >= 0; k--)
            adv[k] = !v_reg[k] || adv[k+1];
        vin = {v_reg[NS-2:0], splat_in.valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            for (int k = 0; k < NS; k++)
                if (adv[k])
                    v_reg[k] <= vin[k];
        end
    end

    assign splat_in.ready = adv[0];

    // lane l < 3 is pos - radius, lane l >= 3 is pos + radius
    logic [31:0] pin [3];
    assign pin[0] = splat_in.pos_x;
    assign pin[1] = splat_in.pos_y;
    assign pin[2] = splat_in.pos_z;

    sbbr_pkg::add_align_t a1_reg [NL];
    logic [31:0]          s2_reg [NL];
    sbbr_pkg::mul_t       m3_reg [NL];
    sbbr_pkg::mul_t       m4_reg [NL];
    logic [31:0]          f5_reg [NL];
    logic [31:0]          c6_reg [NL];
    logic [31:0]          c7_reg [NL];
    logic signed [63:0]   p8_reg [NL];
    logic                 err8_reg;
    logic signed [63:0]   o9_reg [NL];
    logic                 err9_reg;

    // threshold adjust and bucket multiply terms
    logic [31:0]        adj_next [NL];
    logic signed [63:0] p8_next  [NL];
    logic               err8_next;

    always_comb
    begin
        logic signed [32:0] a33;
        logic signed [32:0] b33;
        logic signed [65:0] prod;
        err8_next = 1'b0;
        b33 = $signed({1'b0, div_multiplier_reg});
        for (int l = 0; l < NL; l++)
        begin
            adj_next[l] = c6_reg[l]
                + {31'd0, $signed(c6_reg[l]) < $signed(neg_threshold_reg)}
                + {31'd0, $signed(c6_reg[l]) > $signed(pos_threshold_reg)};
            a33 = $signed({c7_reg[l][31], c7_reg[l]});
            prod = a33 * b33;
            p8_next[l] = prod[63:0];
            if (c7_reg[l] == sbbr_pkg::INT_MIN_BITS || c7_reg[l] == sbbr_pkg::INDEX_FLOOR_MIN)
                err8_next = 1'b1;
        end
    end

    // datapath stages
    always_ff @(posedge clk)
    begin
        for (int l = 0; l < NL; l++)
        begin
            if (adv[0] && vin[0])
                a1_reg[l] <= sbbr_pkg::fadd_align(pin[l % 3], splat_in.splat_radius, l < 3);
            if (adv[1] && vin[1])
                s2_reg[l] <= sbbr_pkg::fadd_round(a1_reg[l]);
            if (adv[2] && vin[2])
                m3_reg[l] <= sbbr_pkg::fmul_prod(s2_reg[l], inv_spacing_reg);
            if (adv[3] && vin[3])
                m4_reg[l] <= sbbr_pkg::fmul_norm(m3_reg[l]);
            if (adv[4] && vin[4])
                f5_reg[l] <= sbbr_pkg::fmul_round(m4_reg[l]);
            if (adv[5] && vin[5])
                c6_reg[l] <= sbbr_pkg::floor_cell(f5_reg[l]);
            if (adv[6] && vin[6])
                c7_reg[l] <= adj_next[l];
            if (adv[7] && vin[7])
                p8_reg[l] <= p8_next[l];
            if (adv[8] && vin[8])
                o9_reg[l] <= err8_reg ? 64'sd0 : (p8_reg[l] >>> div_shift_reg);
        end
        if (adv[7] && vin[7])
            err8_reg <= err8_next;
        if (adv[8] && vin[8])
            err9_reg <= err8_reg;
    end

    // output item
    assign bucket_out.valid       = v_reg[NS-1];
    assign bucket_out.lower_x     = o9_reg[0];
    assign bucket_out.lower_y     = o9_reg[1];
    assign bucket_out.lower_z     = o9_reg[2];
    assign bucket_out.upper_x     = o9_reg[3];
    assign bucket_out.upper_y     = o9_reg[4];
    assign bucket_out.upper_z     = o9_reg[5];
    assign bucket_out.range_error = err9_reg;

    // an error item carries zero coordinates
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        bucket_out.valid && bucket_out.range_error |->
            bucket_out.lower_x == 64'sd0 && bucket_out.upper_x == 64'sd0 &&
            bucket_out.lower_y == 64'sd0 && bucket_out.upper_y == 64'sd0 &&
            bucket_out.lower_z == 64'sd0 && bucket_out.upper_z == 64'sd0)
        else $error("range_error item with nonzero coordinates");

    // input only stalls when every stage is full
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !splat_in.ready |-> (&v_reg) && !bucket_out.ready)
        else $error("input stalled with an empty stage");

    // an accepted item lands in the first stage
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        splat_in.valid && splat_in.ready |=> v_reg[0])
        else $error("accepted item lost at pipeline entry");

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for splat_bounds_to_bucket_range_top: directed and random splats.
// Depends on sbbr_pkg, sbbr_splat_if, sbbr_bucket_if and the top level under test.
`timescale 1ns / 1ps

module tb_top;

    // One bucket range: lower x,y,z then upper x,y,z, plus the error flag
    typedef struct {
        longint coord[6];
        bit     err;
    } bucket_range_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    sbbr_pkg::cfg_reg_t cfg_index;
    logic [31:0]        cfg_data;

    sbbr_splat_if  splat ();
    sbbr_bucket_if bucket ();

    splat_bounds_to_bucket_range_top u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .splat_in   (splat),
        .bucket_out (bucket)
    );

    // Shadow copy of the configuration
    logic [31:0] sh_inv_spacing;
    logic [31:0] sh_div_mult;
    logic [5:0]  sh_div_shift;
    logic [31:0] sh_neg_thr;
    logic [31:0] sh_pos_thr;

    bucket_range_t pending_ranges[$];
    int            fail_count;
    int            sent_count;
    int            checked_count;
    int            snd_idle;
    int            rcv_idle;

    // Clock
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Run limit
    initial
    begin
        #4ms;
        $display("tb: failure");
        $finish;
    end

    // Float bits to real, exact; caller filters exponent 255
    function automatic real float_to_real(input logic [31:0] f);
        real r;
        int  ee;
        if (f[30:23] == 8'd0)
        begin
            r = real'(longint'(f[22:0])) * (2.0 ** (-149));
            if (f[31])
                r = -r;
        end
        else
        begin
            ee = int'(f[30:23]) + 896;
            r = $bitstoreal({f[31], 11'(ee), f[22:0], 29'd0});
        end
        return r;
    endfunction

    // Real to float bits, round to nearest even, with subnormals and overflow
    function automatic logic [31:0] real_to_float(input real x);
        logic [63:0] b;
        logic [63:0] sig;
        logic [63:0] keep;
        logic [63:0] remm;
        logic [63:0] half;
        int          e;
        int          sh;
        b = $realtobits(x);
        if (b[62:0] == 63'd0)
            return {b[63], 31'd0};
        e = int'(b[62:52]) - 1023;
        if (e > 127)
            return {b[63], sbbr_pkg::EXP_MAX, 23'd0};
        sig = {11'd0, 1'b1, b[51:0]};
        sh = (e >= -126) ? 29 : 29 + (-126 - e);
        if (sh > 62)
            return {b[63], 31'd0};
        keep = sig >> sh;
        remm = sig & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        if (remm > half || (remm == half && keep[0]))
            keep = keep + 64'd1;
        if (e < -126)
            return {b[63], keep[30:0]};
        if (keep[24])
        begin
            keep = keep >> 1;
            e = e + 1;
        end
        if (e > 127)
            return {b[63], sbbr_pkg::EXP_MAX, 23'd0};
        return {b[63], 8'(e + 127), keep[22:0]};
    endfunction

    // Cell index of (p +/- r) * scale, floored; specials and overflow give INT_MIN
    function automatic logic [31:0] cell_of(input logic [31:0] p, input logic [31:0] r,
                                            input bit minus);
        logic [31:0] edge_f;
        logic [31:0] scaled;
        real         v;
        real         fl;
        if (p[30:23] == sbbr_pkg::EXP_MAX || r[30:23] == sbbr_pkg::EXP_MAX ||
            sh_inv_spacing[30:23] == sbbr_pkg::EXP_MAX)
            return sbbr_pkg::INT_MIN_BITS;
        v = minus ? float_to_real(p) - float_to_real(r) : float_to_real(p) + float_to_real(r);
        edge_f = real_to_float(v);
        if (edge_f[30:23] == sbbr_pkg::EXP_MAX)
            return sbbr_pkg::INT_MIN_BITS;
        scaled = real_to_float(float_to_real(edge_f) * float_to_real(sh_inv_spacing));
        if (scaled[30:23] == sbbr_pkg::EXP_MAX)
            return sbbr_pkg::INT_MIN_BITS;
        fl = $floor(float_to_real(scaled));
        if (fl >= 2147483648.0 || fl < -2147483648.0)
            return sbbr_pkg::INT_MIN_BITS;
        return 32'(longint'(fl));
    endfunction

    // Full bucket range of one splat under the current configuration
    function automatic bucket_range_t compute_bucket_range(input logic [31:0] px,
            input logic [31:0] py, input logic [31:0] pz, input logic [31:0] rad);
        bucket_range_t     res;
        logic [31:0]       cells[6];
        logic [31:0]       pos[3];
        longint            prod;
        pos[0] = px;
        pos[1] = py;
        pos[2] = pz;
        res.err = 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            cells[a]     = cell_of(pos[a], rad, 1'b1);
            cells[a + 3] = cell_of(pos[a], rad, 1'b0);
        end
        for (int i = 0; i < 6; i++)
        begin
            logic [31:0] u;
            u = cells[i];
            if ($signed(cells[i]) < $signed(sh_neg_thr))
                u = u + 32'd1;
            if ($signed(cells[i]) > $signed(sh_pos_thr))
                u = u + 32'd1;
            cells[i] = u;
            if ($signed(u) <= $signed(sbbr_pkg::INDEX_FLOOR_MIN))
                res.err = 1'b1;
        end
        for (int i = 0; i < 6; i++)
        begin
            prod = longint'($signed(cells[i])) * longint'({32'd0, sh_div_mult});
            res.coord[i] = res.err ? 64'sd0 : (prod >>> sh_div_shift);
        end
        return res;
    endfunction

    // Result checker and receiver stalls
    always @(posedge clk)
    begin
        bucket_range_t got;
        bucket_range_t want;
        bucket.ready <= ($urandom_range(99) >= rcv_idle);
        if (rst_n && bucket.valid && bucket.ready)
        begin
            got.coord[0] = bucket.lower_x;
            got.coord[1] = bucket.lower_y;
            got.coord[2] = bucket.lower_z;
            got.coord[3] = bucket.upper_x;
            got.coord[4] = bucket.upper_y;
            got.coord[5] = bucket.upper_z;
            got.err = bucket.range_error;
            if (pending_ranges.size() == 0)
            begin
                $display("%0t: unexpected result item", $time);
                fail_count++;
            end
            else
            begin
                want = pending_ranges.pop_front();
                checked_count++;
                for (int i = 0; i < 6; i++)
                begin
                    if (got.coord[i] != want.coord[i])
                    begin
                        $display("%0t: coord %0d mismatch: expected %0d actual %0d",
                                 $time, i, want.coord[i], got.coord[i]);
                        fail_count++;
                    end
                end
                if (got.err != want.err)
                begin
                    $display("%0t: range_error mismatch: expected %0d actual %0d",
                             $time, want.err, got.err);
                    fail_count++;
                end
            end
        end
    end

    // Send one splat item, with random idle cycles ahead of it
    task automatic send_splat(input logic [31:0] px, input logic [31:0] py,
                              input logic [31:0] pz, input logic [31:0] rad);
        while ($urandom_range(99) < snd_idle)
        begin
            splat.valid <= 1'b0;
            @(posedge clk);
        end
        pending_ranges.push_back(compute_bucket_range(px, py, pz, rad));
        splat.valid        <= 1'b1;
        splat.pos_x        <= px;
        splat.pos_y        <= py;
        splat.pos_z        <= pz;
        splat.splat_radius <= rad;
        @(posedge clk);
        while (!splat.ready)
            @(posedge clk);
        sent_count++;
    endtask

    // Stop sending, wait for every pending result, then let the pipeline idle before returning
    task automatic drain;
        splat.valid <= 1'b0;
        @(posedge clk);
        while (pending_ranges.size() != 0)
            @(posedge clk);
        repeat (sbbr_pkg::NUM_STAGES + 4) @(posedge clk);
    endtask

    // One register write; the caller drops the write enable afterwards
    task automatic write_reg(input sbbr_pkg::cfg_reg_t idx, input logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            sbbr_pkg::REG_INV_SPACING:    sh_inv_spacing = data;
            sbbr_pkg::REG_DIV_MULTIPLIER: sh_div_mult    = data;
            sbbr_pkg::REG_DIV_SHIFT:      sh_div_shift   = data[5:0];
            sbbr_pkg::REG_NEG_THRESHOLD:  sh_neg_thr     = data;
            sbbr_pkg::REG_POS_THRESHOLD:  sh_pos_thr     = data;
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [31:0] inv, input logic [31:0] mult,
                             input logic [5:0] shift, input logic [31:0] neg,
                             input logic [31:0] pos);
        write_reg(sbbr_pkg::REG_INV_SPACING, inv);
        write_reg(sbbr_pkg::REG_DIV_MULTIPLIER, mult);
        write_reg(sbbr_pkg::REG_DIV_SHIFT, 32'({$urandom_range(1023), shift}));
        write_reg(sbbr_pkg::REG_NEG_THRESHOLD, neg);
        write_reg(sbbr_pkg::REG_POS_THRESHOLD, pos);
        cfg_we <= 1'b0;
    endtask

    // Random float with its exponent field in [elo, ehi]
    function automatic logic [31:0] rand_float(input int elo, input int ehi);
        return {1'($urandom), 8'($urandom_range(ehi, elo)), 23'($urandom)};
    endfunction

    // Reset values: zeros, halves, signs, NaN, infinity, subnormals, int32 overflow
    task automatic test_reset_defaults;
        send_splat(32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'h0000_0000);
        send_splat(32'h3FC0_0000, 32'hBFC0_0000, 32'h4120_0000, 32'h3F00_0000);
        send_splat(32'hBF00_0000, 32'h0000_0001, 32'h8000_0001, 32'h0000_0000);
        send_splat(32'h4F40_0000, 32'h0000_0000, 32'h0000_0000, 32'h3F80_0000);
        send_splat(32'h4EFF_FFFF, 32'hCEFF_FFFF, 32'hCF00_0000, 32'h0000_0000);
        send_splat(sbbr_pkg::FLOAT_QNAN, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_splat(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h7F80_0000);
        send_splat(32'h7F7F_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h7F7F_FFFF);
        send_splat(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
        send_splat(32'h4120_0000, 32'hC120_0000, 32'h3DCC_CCCD, 32'h4000_0000);
        drain();
    endtask

    // Extreme registers: double increment, zero and full multiplier, deep shifts
    task automatic test_register_extremes;
        write_all(32'h3E80_0000, 32'hFFFF_FFFF, 6'd63, 32'h7FFF_FFFF, 32'h8000_0000);
        send_splat(32'h4120_0000, 32'hC120_0000, 32'h0000_0000, 32'h3F80_0000);
        send_splat(32'h4EFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        drain();
        write_all(32'h0000_0000, 32'h0000_0000, 6'd0, 32'h8000_0000, 32'h7FFF_FFFF);
        send_splat(32'h4120_0000, 32'hC2C8_0000, 32'h0000_0000, 32'h3F80_0000);
        drain();
        write_all(32'h0000_0001, 32'hAAAA_AAAB, 6'd33, 32'h0000_0000, 32'h0000_0000);
        send_splat(32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h4B00_0000, 32'h0000_0000);
        send_splat(32'hC2C8_0000, 32'h42C8_0000, 32'h0000_0000, 32'h4080_0000);
        drain();
        write_all(32'h7F80_0000, 32'h5555_5556, 6'd32, 32'hFFFF_FFFE, 32'h0000_0002);
        send_splat(32'h3F80_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        drain();
        write_all(32'h4F00_0000, 32'h0000_0001, 6'd1, 32'h8000_0001, 32'h7FFF_FFFE);
        send_splat(32'h3F80_0000, 32'h3000_0000, 32'hBF80_0000, 32'h0000_0000);
        send_splat(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h3000_0000);
        drain();
    endtask

    // Random splats under random configurations, mostly plausible geometry
    task automatic test_random_stream(input int count);
        logic [31:0] thr_n;
        logic [31:0] thr_p;
        for (int blk = 0; blk < count / 30; blk++)
        begin
            case ($urandom_range(3))
                0: begin thr_n = 32'h8000_0000; thr_p = 32'h7FFF_FFFF; end
                1: begin thr_n = 32'h0000_0000; thr_p = 32'h0000_0000; end
                2: begin thr_n = 32'($signed(-$urandom_range(50))); thr_p = $urandom_range(50); end
                default: begin thr_n = $urandom; thr_p = $urandom; end
            endcase
            write_all({1'b0, 8'($urandom_range(140, 110)), 23'($urandom)},
                      ($urandom_range(3) == 0) ? 32'($urandom_range(16)) : $urandom,
                      6'($urandom_range(3) == 0 ? $urandom_range(63) : $urandom_range(40, 28)),
                      thr_n, thr_p);
            for (int i = 0; i < 30; i++)
            begin
                if ($urandom_range(9) == 0)
                    send_splat($urandom, $urandom, $urandom, $urandom);
                else
                    send_splat(rand_float(100, 155), rand_float(100, 155), rand_float(100, 155),
                               rand_float(95, 140) & 32'h7FFF_FFFF);
            end
            drain();
        end
    endtask

    // Main sequence
    initial
    begin
        rst_n              = 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= sbbr_pkg::REG_INV_SPACING;
        cfg_data           <= 32'd0;
        splat.valid        <= 1'b0;
        splat.pos_x        <= 32'd0;
        splat.pos_y        <= 32'd0;
        splat.pos_z        <= 32'd0;
        splat.splat_radius <= 32'd0;
        fail_count    = 0;
        sent_count    = 0;
        checked_count = 0;
        snd_idle      = 17;
        rcv_idle      = 74;
        sh_inv_spacing = sbbr_pkg::INV_SPACING_RESET;
        sh_div_mult    = sbbr_pkg::DIV_MULTIPLIER_RESET;
        sh_div_shift   = sbbr_pkg::DIV_SHIFT_RESET;
        sh_neg_thr     = sbbr_pkg::NEG_THRESHOLD_RESET;
        sh_pos_thr     = sbbr_pkg::POS_THRESHOLD_RESET;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_register_extremes();
        test_random_stream(210);
        snd_idle = 74;
        rcv_idle = 17;
        test_random_stream(210);
        snd_idle = 0;
        rcv_idle = 0;
        test_random_stream(240);
        drain();

        $display("Sent %0d splats, checked %0d bucket ranges over several register settings",
                 sent_count, checked_count);
        $display("Covered NaN, infinity, subnormal, overflow and threshold cases with stalls");
        if (fail_count == 0 && pending_ranges.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
